@@ rtl/core/e2p_pkg.sv @@
package e2p_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SRC_WIDTH_DEF  = 8192;
  localparam int DST_COORD_BITS_DEF = 12;
  localparam int ANGLE_BITS_DEF     = 18;

  // Fixed field widths
  localparam int VEC_W      = 63;
  localparam int COMP_W     = 21;
  localparam int SRC_W_W    = 14;
  localparam int SRC_H_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int SQRT_BITS  = 31;
  localparam int MAG_BITS   = 30;
  localparam int TAB_LEN    = 24;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H    = 3'd4;

  localparam logic [SRC_W_W-1:0] SRC_W_RST = 14'd4096;
  localparam logic [SRC_H_W-1:0] SRC_H_RST = 13'd2048;

  // atan(2^-i) in turns, 32 fraction bits
  localparam logic [31:0] STEP_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // Round the step angle half up to the angle resolution
  function automatic logic [31:0] step_angle(input int i, input int ab);
    logic [32:0] t;
    t = {1'b0, STEP_TAB[i]} + (33'd1 << (31 - ab));
    t = t >> (32 - ab);
    return t[31:0];
  endfunction

  // Cycles from an accepted request to its result strobe
  function automatic int e2p_latency(input int ab);
    return ab + 12 + SQRT_BITS;
  endfunction

endpackage

@@ rtl/core/e2p_isqrt.sv @@
module e2p_isqrt import e2p_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [2*SQRT_BITS-1:0] in_rad,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_vld,
  output logic [SQRT_BITS-1:0]   out_root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int N = SQRT_BITS;

  logic [2*N-1:0]  rad_r  [0:N];
  logic [N:0]      rem_r  [0:N];
  logic [N-1:0]    root_r [0:N];
  logic [SIDE_W-1:0] side_r [0:N];
  logic [N:0]      vld_r;

  // Load the radicand
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    rad_r[0]  <= in_rad;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    side_r[0] <= in_side;
  end

  // One root bit per stage, restoring digit recurrence
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N+2:0] rem_sh;
    logic [N+2:0] trial;
    logic         ge;
    logic [N+2:0] rem_nxt;

    always_comb begin
      rem_sh  = {rem_r[k], rad_r[k][2*N-1 -: 2]};
      trial   = {1'b0, root_r[k], 2'b01};
      ge      = (rem_sh >= trial);
      rem_nxt = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      rad_r[k+1]  <= rad_r[k] << 2;
      rem_r[k+1]  <= rem_nxt[N:0];
      root_r[k+1] <= {root_r[k][N-2:0], ge};
      side_r[k+1] <= side_r[k];
    end
  end

  assign out_vld  = vld_r[N];
  assign out_root = root_r[N];
  assign out_side = side_r[N];

endmodule

@@ rtl/core/e2p_cordic.sv @@
module e2p_cordic import e2p_pkg::*; #(
  parameter int CW = 40,
  parameter int AB = ANGLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic signed [AB+1:0] z_out
);

  localparam int AW = AB + 2;
  localparam logic signed [AW-1:0] QUARTER = AW'(1) <<< (AB - 2);
  localparam logic signed [AW-1:0] HALF    = AW'(1) <<< (AB - 1);

  logic signed [CW-1:0] x_r [0:AB];
  logic signed [CW-1:0] y_r [0:AB];
  logic signed [AW-1:0] z_r [0:AB];
  logic                 fix_r [0:AB];

  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  logic signed [AW-1:0] z0;
  logic                 fix0;

  // Resolve axis cases and fold the left half-plane
  always_comb begin
    x0   = x_in;
    y0   = y_in;
    z0   = '0;
    fix0 = 1'b0;
    if (y_in == '0) begin
      fix0 = 1'b1;
      z0   = (x_in >= 0) ? '0 : HALF;
    end else if (x_in == '0) begin
      fix0 = 1'b1;
      z0   = (y_in > 0) ? QUARTER : -QUARTER;
    end else if (x_in < 0) begin
      if (y_in > 0) begin
        z0 = QUARTER;
        x0 = y_in;
        y0 = -x_in;
      end else begin
        z0 = -QUARTER;
        x0 = -y_in;
        y0 = x_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= x0;
    y_r[0]   <= y0;
    z_r[0]   <= z0;
    fix_r[0] <= fix0;
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < AB; i++) begin : g_iter
    localparam logic signed [AW-1:0] STEP = AW'(step_angle(i, AB));
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      fix_r[i+1] <= fix_r[i];
      if (fix_r[i]) begin
        x_r[i+1] <= x_r[i];
        y_r[i+1] <= y_r[i];
        z_r[i+1] <= z_r[i];
      end else if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + dy;
        y_r[i+1] <= y_r[i] - dx;
        z_r[i+1] <= z_r[i] + STEP;
      end else begin
        x_r[i+1] <= x_r[i] - dy;
        y_r[i+1] <= y_r[i] + dx;
        z_r[i+1] <= z_r[i] - STEP;
      end
    end
  end

  assign z_out = z_r[AB];

endmodule

@@ rtl/core/equirect_to_perspective_remap_unit.sv @@
// Equirectangular-to-perspective coordinate remap.
//
// Input channel: raise start with in_dst_row / in_dst_col; the request is
// taken at any edge where start is high and busy is low. busy is only high
// during reset and for the first cycle after it, so a new pixel position can
// be taken in every cycle.
// Result channel: out_strobe marks one cycle that carries out_src_col,
// out_src_row and out_src_pixel_index. Results come in request order.
// Requests pass through the 31-stage square-root pipeline and then the
// ANGLE_BITS-stage CORDIC units; throughput is one request per cycle.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 origin,
// 1 column step, 2 row step, 3 source width, 4 source height). Write only
// while no request is in flight.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall; results are never held back.
module equirect_to_perspective_remap_unit import e2p_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
  parameter int DST_COORD_BITS = DST_COORD_BITS_DEF,
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [11:0]          in_dst_row,
  input  logic [11:0]          in_dst_col,
  output logic                 out_strobe,
  output logic [12:0]          out_src_col,
  output logic [11:0]          out_src_row,
  output logic [24:0]          out_src_pixel_index,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VEC_W-1:0]     cfg_wdata
);

  localparam int DB  = DST_COORD_BITS;
  localparam int AB  = ANGLE_BITS;
  localparam int AW  = AB + 2;
  localparam int PW  = COMP_W + DB + 1;
  localparam int VW  = PW + 2;
  localparam int SMAX = VW - MAG_BITS;
  localparam int SW  = $clog2(SMAX + 1);
  localparam int CW  = VW + 2;
  localparam int CL  = AB + 1;
  localparam int SIDE_W = SQRT_BITS + 2 * VW;
  localparam logic [SRC_W_W:0] W_CAP = (SRC_W_W + 1)'(MAX_SRC_WIDTH);
  localparam logic [SRC_W_W:0] H_CAP = (SRC_W_W + 1)'(MAX_SRC_WIDTH / 2);
  localparam logic signed [AW-1:0] QUARTER = AW'(1) <<< (AB - 2);
  localparam logic signed [AW-1:0] HALF    = AW'(1) <<< (AB - 1);
  localparam logic signed [AW:0]   FULL    = (AW + 1)'(1) <<< AB;

  // Configuration registers
  logic [VEC_W-1:0]   origin_r;
  logic [VEC_W-1:0]   col_step_r;
  logic [VEC_W-1:0]   row_step_r;
  logic [SRC_W_W-1:0] src_w_r;
  logic [SRC_H_W-1:0] src_h_r;
  logic               busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r   <= '0;
      col_step_r <= '0;
      row_step_r <= '0;
      src_w_r    <= SRC_W_RST;
      src_h_r    <= SRC_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN:   origin_r   <= cfg_wdata;
        REG_COL_STEP: col_step_r <= cfg_wdata;
        REG_ROW_STEP: row_step_r <= cfg_wdata;
        REG_SRC_W:    src_w_r    <= cfg_wdata[SRC_W_W-1:0];
        REG_SRC_H:    src_h_r    <= cfg_wdata[SRC_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off requests for one cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;

  // Effective image size
  logic [SRC_W_W-1:0] w_eff;
  logic [SRC_W_W-1:0] h_eff;
  logic [SRC_W_W-1:0] wm1;
  logic [SRC_W_W-1:0] hm1;

  always_comb begin
    w_eff = ({1'b0, src_w_r} > W_CAP) ? W_CAP[SRC_W_W-1:0] : src_w_r;
    h_eff = ({2'b0, src_h_r} > H_CAP) ? H_CAP[SRC_W_W-1:0] : {1'b0, src_h_r};
    wm1   = (w_eff != '0) ? w_eff - 1'b1 : '0;
    hm1   = (h_eff != '0) ? h_eff - 1'b1 : '0;
  end

  // Stage A: capture the request
  logic          a_vld_r;
  logic [DB-1:0] a_row_r;
  logic [DB-1:0] a_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start & ~busy_r;
    end
    a_row_r <= DB'(in_dst_row);
    a_col_r <= DB'(in_dst_col);
  end

  // Stage B: step products per component
  logic                 b_vld_r;
  logic signed [PW-1:0] b_pc_r [3];
  logic signed [PW-1:0] b_pr_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_prod
    logic signed [COMP_W-1:0] cs;
    logic signed [COMP_W-1:0] rs;
    assign cs = col_step_r[COMP_W*c +: COMP_W];
    assign rs = row_step_r[COMP_W*c +: COMP_W];
    always_ff @(posedge clk) begin
      b_pc_r[c] <= PW'($signed({1'b0, a_col_r}) * cs);
      b_pr_r[c] <= PW'($signed({1'b0, a_row_r}) * rs);
    end
  end

  // Stage C: sum the ray
  logic                 c_vld_r;
  logic signed [VW-1:0] c_v_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_sum
    logic signed [COMP_W-1:0] oc;
    assign oc = origin_r[COMP_W*c +: COMP_W];
    always_ff @(posedge clk) begin
      c_v_r[c] <= VW'(oc) + VW'(b_pc_r[c]) + VW'(b_pr_r[c]);
    end
  end

  // Stage D: scale magnitudes below 2^30
  logic [VW-1:0] ax, ay, az, mx;
  logic [SW-1:0] sh;
  logic [VW-1:0] ays_w;

  always_comb begin
    ax = c_v_r[0][VW-1] ? VW'(-c_v_r[0]) : VW'(c_v_r[0]);
    ay = c_v_r[1][VW-1] ? VW'(-c_v_r[1]) : VW'(c_v_r[1]);
    az = c_v_r[2][VW-1] ? VW'(-c_v_r[2]) : VW'(c_v_r[2]);
    mx = (ax > ay) ? ax : ay;
    if (az > mx) mx = az;
    sh = SW'(SMAX);
    for (int k = SMAX; k >= 0; k--) begin
      if ((mx >> k) < (VW'(1) << MAG_BITS)) sh = SW'(k);
    end
    ays_w = ay >> sh;
  end

  logic                    d_vld_r;
  logic [MAG_BITS-1:0]     d_axs_r;
  logic [MAG_BITS-1:0]     d_azs_r;
  logic signed [MAG_BITS:0] d_vys_r;
  logic signed [VW-1:0]    d_vx_r;
  logic signed [VW-1:0]    d_vz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
    d_axs_r <= MAG_BITS'(ax >> sh);
    d_azs_r <= MAG_BITS'(az >> sh);
    d_vys_r <= c_v_r[1][VW-1] ? -$signed({1'b0, ays_w[MAG_BITS-1:0]})
                              :  $signed({1'b0, ays_w[MAG_BITS-1:0]});
    d_vx_r  <= c_v_r[0];
    d_vz_r  <= c_v_r[2];
  end

  // Stage E: squares
  logic                     e_vld_r;
  logic [2*MAG_BITS-1:0]    e_sqx_r;
  logic [2*MAG_BITS-1:0]    e_sqz_r;
  logic signed [MAG_BITS:0] e_vys_r;
  logic signed [VW-1:0]     e_vx_r;
  logic signed [VW-1:0]     e_vz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= d_vld_r;
    end
    e_sqx_r <= d_axs_r * d_axs_r;
    e_sqz_r <= d_azs_r * d_azs_r;
    e_vys_r <= d_vys_r;
    e_vx_r  <= d_vx_r;
    e_vz_r  <= d_vz_r;
  end

  // Square root of the horizontal magnitude
  logic                   q_vld;
  logic [SQRT_BITS-1:0]   q_root;
  logic [SIDE_W-1:0]      q_side;
  logic signed [MAG_BITS:0] q_vys;
  logic signed [VW-1:0]   q_vx;
  logic signed [VW-1:0]   q_vz;

  e2p_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (e_vld_r),
    .in_rad   ((2*SQRT_BITS)'({1'b0, e_sqx_r} + {1'b0, e_sqz_r})),
    .in_side  ({e_vys_r, e_vx_r, e_vz_r}),
    .out_vld  (q_vld),
    .out_root (q_root),
    .out_side (q_side)
  );

  assign {q_vys, q_vx, q_vz} = q_side;

  // Polar angle and longitude
  logic signed [AW-1:0] z_theta;
  logic signed [AW-1:0] z_phi;

  e2p_cordic #(.CW(CW), .AB(AB)) u_cordic_theta (
    .clk   (clk),
    .x_in  (CW'(q_vys)),
    .y_in  (CW'($signed({1'b0, q_root}))),
    .z_out (z_theta)
  );

  e2p_cordic #(.CW(CW), .AB(AB)) u_cordic_phi (
    .clk   (clk),
    .x_in  (CW'(q_vz)),
    .y_in  (CW'(q_vx)),
    .z_out (z_phi)
  );

  // Carry the case flags alongside the CORDIC stages
  logic [CL-1:0] k_vld_r;
  logic [CL-1:0] k_zray_r;
  logic [CL-1:0] k_vx0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_vld_r <= '0;
    end else begin
      k_vld_r <= {k_vld_r[CL-2:0], q_vld};
    end
    k_zray_r <= {k_zray_r[CL-2:0], (q_root == '0) && (q_vys == '0)};
    k_vx0_r  <= {k_vx0_r[CL-2:0], q_vx == '0};
  end

  // Stage G: special cases and saturation
  logic signed [AW-1:0] theta_s;
  logic signed [AW:0]   u_s;
  logic                 g_vld_r;
  logic [AB-1:0]        g_urow_r;
  logic [AB:0]          g_ucol_r;

  always_comb begin
    theta_s = k_zray_r[CL-1] ? QUARTER : z_theta;
    if (theta_s < 0)    theta_s = '0;
    if (theta_s > HALF) theta_s = HALF;
    u_s = (AW + 1)'(HALF) + (k_vx0_r[CL-1] ? '0 : (AW + 1)'(z_phi));
    if (u_s < 0)    u_s = '0;
    if (u_s > FULL) u_s = FULL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= k_vld_r[CL-1];
    end
    g_urow_r <= AB'(theta_s);
    g_ucol_r <= (AB + 1)'(u_s);
  end

  // Stage H: scale angles to pixels
  logic                   h_vld_r;
  logic [AB+SRC_W_W:0]    h_pcol_r;
  logic [AB+SRC_W_W-1:0]  h_prow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else begin
      h_vld_r <= g_vld_r;
    end
    h_pcol_r <= g_ucol_r * wm1;
    h_prow_r <= g_urow_r * hm1;
  end

  // Stage I: drop fraction and clamp
  logic [SRC_W_W:0]   scol_w;
  logic [SRC_W_W:0]   srow_w;
  logic               i_vld_r;
  logic [SRC_W_W-1:0] i_scol_r;
  logic [SRC_W_W-1:0] i_srow_r;

  always_comb begin
    scol_w = (SRC_W_W + 1)'(h_pcol_r >> AB);
    srow_w = (SRC_W_W + 1)'(h_prow_r >> (AB - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_vld_r <= 1'b0;
    end else begin
      i_vld_r <= h_vld_r;
    end
    i_scol_r <= (scol_w > {1'b0, wm1}) ? wm1 : scol_w[SRC_W_W-1:0];
    i_srow_r <= (srow_w > {1'b0, hm1}) ? hm1 : srow_w[SRC_W_W-1:0];
  end

  // Stage J: row offset
  logic                   j_vld_r;
  logic [2*SRC_W_W-1:0]   j_roff_r;
  logic [SRC_W_W-1:0]     j_scol_r;
  logic [SRC_W_W-1:0]     j_srow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_vld_r <= 1'b0;
    end else begin
      j_vld_r <= i_vld_r;
    end
    j_roff_r <= i_srow_r * w_eff;
    j_scol_r <= i_scol_r;
    j_srow_r <= i_srow_r;
  end

  // Stage K: result register
  logic        out_strobe_r;
  logic [12:0] out_col_r;
  logic [11:0] out_row_r;
  logic [24:0] out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= j_vld_r;
    end
    out_col_r <= j_scol_r[12:0];
    out_row_r <= j_srow_r[11:0];
    out_idx_r <= 25'(j_roff_r + (2*SRC_W_W)'(j_scol_r));
  end

  assign out_strobe          = out_strobe_r;
  assign out_src_col         = out_col_r;
  assign out_src_row         = out_row_r;
  assign out_src_pixel_index = out_idx_r;

endmodule

@@ rtl/core/e2p_checker.sv @@
module e2p_checker import e2p_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  localparam int LAT = e2p_latency(ANGLE_BITS);
  localparam int CNT_W = $clog2(LAT + 1);

  logic [CNT_W-1:0] warm_cnt_r;
  logic             warm;

  // Count cycles since reset until the pipeline holds only fresh requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_cnt_r <= '0;
    end else if (warm_cnt_r != CNT_W'(LAT)) begin
      warm_cnt_r <= warm_cnt_r + 1'b1;
    end
  end
  assign warm = (warm_cnt_r == CNT_W'(LAT));

  // Every result comes from a request a fixed latency earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_strobe) |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching request");

  // Every request yields its result after the fixed latency
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && $past(start && !busy, LAT)) |-> out_strobe)
    else $error("request lost in the pipeline");

  // Requests are held off right after reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> busy)
    else $error("busy low in the first cycle after reset");

endmodule

bind equirect_to_perspective_remap_unit e2p_checker #(.ANGLE_BITS(ANGLE_BITS)) u_e2p_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);
